@@ hw/rtl/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, constants and a ring index helper for the double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

    localparam int DEPTH    = 16;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);

    localparam logic [2:0] ACT_INS_FRONT = 3'd0;
    localparam logic [2:0] ACT_INS_REAR  = 3'd1;
    localparam logic [2:0] ACT_REM_FRONT = 3'd2;
    localparam logic [2:0] ACT_REM_REAR  = 3'd3;
    localparam logic [2:0] ACT_LIST      = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    localparam logic [IDX_W:0]   DEPTH_X   = (IDX_W + 1)'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    typedef struct packed {
        logic [2:0]               action;
        logic signed [DATA_W-1:0] data_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] data_out;
        logic                     last;
    } t_out_item;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH_FRONT,
        OP_PUSH_REAR,
        OP_POP_FRONT,
        OP_POP_REAR,
        OP_LIST_START,
        OP_LIST_NEXT
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic       report;
        logic [1:0] rpt_status;
        logic       emit;
        logic       emit_last;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic out_free;
        logic idx_last;
    } t_dp_sts;

    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_X) begin
            sum = sum - DEPTH_X;
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/deq_ram.sv @@
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/deq_ctrl.sv @@
// ----------------------------------------------------------------------------
// deq_ctrl
// Request decode and sequencing: single-result requests, removes that wait on
// the RAM read, and list walks one element per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ctrl
    import deq_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [2:0] i_action,
    output logic            o_in_ready,
    input  wire t_dp_sts    i_sts,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_LIST = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   take;

    assign o_in_ready = (r_state == S_IDLE) && i_sts.out_free;
    assign take       = o_in_ready && i_in_valid;

    always_comb begin
        n_state          = r_state;
        o_cmd.op         = OP_NONE;
        o_cmd.report     = 1'b0;
        o_cmd.rpt_status = ST_OK;
        o_cmd.emit       = 1'b0;
        o_cmd.emit_last  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    case (i_action)
                        ACT_INS_FRONT, ACT_INS_REAR: begin
                            o_cmd.report = 1'b1;
                            if (i_sts.full) begin
                                o_cmd.rpt_status = ST_OVERFLOW;
                            end else begin
                                o_cmd.op = (i_action == ACT_INS_FRONT) ? OP_PUSH_FRONT
                                                                       : OP_PUSH_REAR;
                            end
                        end
                        ACT_REM_FRONT, ACT_REM_REAR: begin
                            if (i_sts.empty) begin
                                o_cmd.report     = 1'b1;
                                o_cmd.rpt_status = ST_UNDERFLOW;
                            end else begin
                                o_cmd.op = (i_action == ACT_REM_FRONT) ? OP_POP_FRONT
                                                                       : OP_POP_REAR;
                                n_state  = S_POP;
                            end
                        end
                        ACT_LIST: begin
                            if (i_sts.empty) begin
                                o_cmd.report     = 1'b1;
                                o_cmd.rpt_status = ST_EMPTY;
                            end else begin
                                o_cmd.op = OP_LIST_START;
                                n_state  = S_LIST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_LIST: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = i_sts.idx_last;
                    if (i_sts.idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.op = OP_LIST_NEXT;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/deq_dp.sv @@
// ----------------------------------------------------------------------------
// deq_dp
// Ring pointers, fill count, list cursor, entry RAM and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_dp
    import deq_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [DATA_W-1:0]  i_data_in,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_sts                 o_sts,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_out_item               o_out_item
);

    logic [IDX_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_out_valid;
    t_out_item         r_out;

    logic              wr_en;
    logic              rd_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [IDX_W-1:0]  rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic [IDX_W-1:0]  head_dec;
    logic [IDX_W-1:0]  head_inc;
    logic [IDX_W-1:0]  cnt_lo;
    logic [IDX_W-1:0]  cnt_m1;

    assign cnt_lo   = r_count[IDX_W-1:0];
    assign cnt_m1   = IDX_W'(r_count - 1'b1);
    assign head_dec = (r_head == '0) ? LAST_IDX : r_head - 1'b1;
    assign head_inc = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;

    assign o_sts.full     = (r_count == FULL_CNT);
    assign o_sts.empty    = (r_count == '0);
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.idx_last = (CNT_W'(r_idx) == r_count - 1'b1);

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_idx   = r_idx;
        wr_en   = 1'b0;
        rd_en   = 1'b0;
        wr_addr = r_head;
        rd_addr = r_head;
        case (i_cmd.op)
            OP_PUSH_FRONT: begin
                wr_en   = 1'b1;
                wr_addr = head_dec;
                n_head  = head_dec;
                n_count = r_count + 1'b1;
            end
            OP_PUSH_REAR: begin
                wr_en   = 1'b1;
                wr_addr = ring_add(r_head, cnt_lo);
                n_count = r_count + 1'b1;
            end
            OP_POP_FRONT: begin
                rd_en   = 1'b1;
                rd_addr = r_head;
                n_head  = head_inc;
                n_count = r_count - 1'b1;
            end
            OP_POP_REAR: begin
                rd_en   = 1'b1;
                rd_addr = ring_add(r_head, cnt_m1);
                n_count = r_count - 1'b1;
            end
            OP_LIST_START: begin
                rd_en   = 1'b1;
                rd_addr = r_head;
                n_idx   = '0;
            end
            OP_LIST_NEXT: begin
                rd_en   = 1'b1;
                rd_addr = ring_add(r_head, r_idx + 1'b1);
                n_idx   = r_idx + 1'b1;
            end
            default: begin
            end
        endcase
    end

    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_data_in),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_idx   <= n_idx;
            if (i_cmd.report || i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.report) begin
            r_out.status   <= i_cmd.rpt_status;
            r_out.data_out <= '0;
            r_out.last     <= 1'b1;
        end else if (i_cmd.emit) begin
            r_out.status   <= ST_OK;
            r_out.data_out <= rd_data;
            r_out.last     <= i_cmd.emit_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

@@ hw/rtl/double_ended_queue_unit.sv @@
// Insert and failed requests: result in the output register in the cycle after the transfer.
// Remove: result loaded after the registered RAM read, once the output register is free.
// List of N entries: first result after the RAM read, then one per cycle while the output is accepted.
// A new request is taken once the last result of the previous one is loaded and the output is free.
// Synchronous active-low reset clears head, count and control; RAM contents are kept.
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Double-ended queue of signed 32-bit values held in a RAM ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_unit
    import deq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    deq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_item.action),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    deq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_in   (i_in_item.data_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

@@ hw/rtl/deq_checker.sv @@
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks for the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_checker
    import deq_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire t_in_item  i_in_item,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output transfer changed while stalled");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_OK |-> o_out_item.last)
        else $error("error status without last");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_OK |-> o_out_item.data_out == '0)
        else $error("error status with nonzero data");

    a_ins_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready &&
        (i_in_item.action == ACT_INS_FRONT || i_in_item.action == ACT_INS_REAR)
        |=> o_out_valid && o_out_item.last && o_out_item.data_out == '0 &&
            (o_out_item.status == ST_OK || o_out_item.status == ST_OVERFLOW))
        else $error("insert did not produce its result");

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (.*);

`default_nettype wire
